[rtl/lsb_first_bit_packer_core_assert.svh]
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_core_assert.svh
// Assertion macros for the bit packer core.
// ----------------------------------------------------------------------------
`ifndef LSB_FIRST_BIT_PACKER_CORE_ASSERT_SVH
`define LSB_FIRST_BIT_PACKER_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define LBP_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("bit packer assertion failed");
// next-cycle implication
`define LBP_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("bit packer assertion failed");
`else
`define LBP_ASSERT_SAME(label, clk, rst_n, a, b)
`define LBP_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

[rtl/lsbp_pkg.sv]
// ----------------------------------------------------------------------------
// lsbp_pkg
// Types and constants shared by the bit packer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsbp_pkg;

    localparam int BUF_BYTES = 256;
    localparam int ADDR_W    = $clog2(BUF_BYTES);
    localparam int MAX_BITS  = 32;

    localparam logic [2:0] FN_CLEAR   = 3'd0;
    localparam logic [2:0] FN_ADD_U   = 3'd1;
    localparam logic [2:0] FN_ADD_S   = 3'd2;
    localparam logic [2:0] FN_GET_U   = 3'd3;
    localparam logic [2:0] FN_GET_S   = 3'd4;
    localparam logic [2:0] FN_SET_POS = 3'd5;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_RANGE   = 2'd1;
    localparam logic [1:0] STAT_OVERRUN = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic [2:0] rd_idx;
        logic       proc_en;
        logic [2:0] proc_idx;
        logic       finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] n_bytes;
        logic       out_busy;
    } dp_status_t;

endpackage

[rtl/lsbp_ram.sv]
// ----------------------------------------------------------------------------
// lsbp_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/lsbp_dp.sv]
// ----------------------------------------------------------------------------
// lsbp_dp
// Datapath: item registers, bit position, byte store with valid bits,
// byte merge and extract window, result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsbp_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lsbp_pkg::ctrl_cmd_t    cmd,
    output lsbp_pkg::dp_status_t   dp_stat,
    input  logic [2:0]             func,
    input  logic [31:0]            value,
    input  logic [5:0]             bit_count,
    input  logic [11:0]            new_position,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [31:0]            read_value,
    output logic [1:0]             status,
    output logic [11:0]            position_after,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [8:0]             cfg_data
);

    import lsbp_pkg::*;

    logic [2:0]           func_reg;
    logic [31:0]          val_reg;
    logic [5:0]           n_reg;
    logic [11:0]          newpos_reg;
    logic [11:0]          pos_reg;
    logic [11:0]          pos_next;
    logic [8:0]           bb_reg;
    logic [BUF_BYTES-1:0] vld_reg;
    logic [39:0]          rwin_reg;
    logic                 over_reg;
    logic                 rd_ok_reg;
    logic                 out_valid_reg;
    logic [31:0]          rv_reg;
    logic [1:0]           st_reg;
    logic [11:0]          pa_reg;

    logic [2:0]           s;
    logic [32:0]          lm33;
    logic [31:0]          lm;
    logic [31:0]          lm1;
    logic [39:0]          wwin;
    logic [39:0]          mwin;
    logic                 is_add;
    logic                 is_get;
    logic                 is_access;
    logic [6:0]           span;
    logic [8:0]           bb_eff;
    logic [8:0]           rd_addr9;
    logic [8:0]           pr_addr9;
    logic                 rd_inr;
    logic                 pr_inr;
    logic [5:0]           pr_off;
    logic [7:0]           ram_q;
    logic [7:0]           old_byte;
    logic [7:0]           wbyte;
    logic [7:0]           mbyte;
    logic                 ram_we;
    logic [31:0]          hi_mask;
    logic [31:0]          hi_bits;
    logic                 rng_flag;
    logic [39:0]          rsh;
    logic [31:0]          ext;
    logic                 sgn;
    logic [31:0]          rv;
    logic [1:0]           st_val;

    assign s    = pos_reg[2:0];
    assign lm33 = (33'd1 << n_reg) - 33'd1;
    assign lm   = lm33[31:0];
    assign lm1  = lm33[32:1];

    assign is_add    = (func_reg == FN_ADD_U) || (func_reg == FN_ADD_S);
    assign is_get    = (func_reg == FN_GET_U) || (func_reg == FN_GET_S);
    assign is_access = (is_add || is_get) && (n_reg != 6'd0);

    // window of bits aligned to the first byte touched
    assign wwin = {8'h00, val_reg & lm} << s;
    assign mwin = {8'h00, lm} << s;

    assign span             = {4'd0, s} + {1'b0, n_reg} + 7'd7;
    assign dp_stat.n_bytes  = is_access ? span[5:3] : 3'd0;
    assign dp_stat.out_busy = out_valid_reg && out_stall;

    assign bb_eff   = (bb_reg > 9'(BUF_BYTES)) ? 9'(BUF_BYTES) : bb_reg;
    assign rd_addr9 = pos_reg[11:3] + {6'd0, cmd.rd_idx};
    assign pr_addr9 = pos_reg[11:3] + {6'd0, cmd.proc_idx};
    assign rd_inr   = rd_addr9 < bb_eff;
    assign pr_inr   = pr_addr9 < bb_eff;
    assign pr_off   = {cmd.proc_idx, 3'b000};

    // never-written or out-of-range bytes read as zero
    assign old_byte = rd_ok_reg ? ram_q : 8'h00;
    assign wbyte    = wwin[pr_off +: 8];
    assign mbyte    = mwin[pr_off +: 8];
    assign ram_we   = cmd.proc_en && pr_inr && is_add;

    lsbp_ram #(
        .WIDTH(8),
        .DEPTH(BUF_BYTES)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(pr_addr9[ADDR_W-1:0]),
        .wdata(old_byte | (wbyte & mbyte)),
        .re   (cmd.rd_en),
        .raddr(rd_addr9[ADDR_W-1:0]),
        .rdata(ram_q)
    );

    // signed add fits when bits n-1 and up are all equal
    assign hi_mask = ~lm1;
    assign hi_bits = val_reg & hi_mask;

    always_comb
    begin
        rng_flag = 1'b0;
        if (func_reg == FN_ADD_U)
        begin
            rng_flag = (val_reg & ~lm) != 32'd0;
        end
        else if (func_reg == FN_ADD_S)
        begin
            rng_flag = !((hi_bits == 32'd0) || (hi_bits == hi_mask));
        end
    end

    assign rsh = rwin_reg >> s;
    assign ext = rsh[31:0] & lm;
    assign sgn = |(ext & hi_mask);
    assign rv  = ((func_reg == FN_GET_S) && sgn) ? (ext | ~lm) : ext;

    always_comb
    begin
        st_val = STAT_OK;
        if (is_access && over_reg)
        begin
            st_val = STAT_OVERRUN;
        end
        else if (is_access && rng_flag)
        begin
            st_val = STAT_RANGE;
        end
    end

    always_comb
    begin
        case (func_reg) inside
            FN_CLEAR:                               pos_next = 12'd0;
            FN_SET_POS:                             pos_next = newpos_reg;
            FN_ADD_U, FN_ADD_S, FN_GET_U, FN_GET_S: pos_next = pos_reg + {6'd0, n_reg};
            default:                                pos_next = pos_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 12'd0;
            bb_reg        <= 9'(BUF_BYTES);
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                bb_reg <= cfg_data;
            end
            if (ram_we)
            begin
                vld_reg[pr_addr9[ADDR_W-1:0]] <= 1'b1;
            end
            if (cmd.finish)
            begin
                pos_reg       <= pos_next;
                out_valid_reg <= 1'b1;
                if (func_reg == FN_CLEAR)
                begin
                    vld_reg <= '0;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= func;
            val_reg    <= value;
            n_reg      <= (bit_count > 6'(MAX_BITS)) ? 6'(MAX_BITS) : bit_count;
            newpos_reg <= new_position;
            rwin_reg   <= '0;
            over_reg   <= 1'b0;
        end
        if (cmd.rd_en)
        begin
            rd_ok_reg <= rd_inr && vld_reg[rd_addr9[ADDR_W-1:0]];
        end
        if (cmd.proc_en)
        begin
            if (!pr_inr)
            begin
                over_reg <= 1'b1;
            end
            if (is_get)
            begin
                rwin_reg[pr_off +: 8] <= old_byte;
            end
        end
        if (cmd.finish)
        begin
            rv_reg <= is_get ? rv : 32'd0;
            st_reg <= st_val;
            pa_reg <= pos_next;
        end
    end

    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign read_value     = rv_reg;
    assign status         = st_reg;
    assign position_after = pa_reg;

endmodule

[rtl/lsbp_ctrl.sv]
// ----------------------------------------------------------------------------
// lsbp_ctrl
// Controller: accepts an item, steps the byte read/merge sequence and
// hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsbp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  lsbp_pkg::dp_status_t  dp_stat,
    output lsbp_pkg::ctrl_cmd_t   cmd
);

    import lsbp_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.rd_idx   = cnt_reg;
        cmd.proc_idx = cnt_reg - 3'd1;
        in_stall     = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = 3'd0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                // read byte cnt while merging byte cnt-1
                cmd.rd_en   = cnt_reg < dp_stat.n_bytes;
                cmd.proc_en = cnt_reg != 3'd0;
                if (cnt_reg == dp_stat.n_bytes)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            S_FINISH:
            begin
                // hold until the output register frees up
                if (!dp_stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/lsb_first_bit_packer_core.sv]
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_core
// LSB-first bit packer and unpacker over a 256-byte store.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid / in_stall  | func value bit_count new_position
//   out     | output    | out_valid / out_stall| read_value status position_after
//   cfg     | input     | cfg_valid / cfg_ready| cfg_data (buffer_bytes)
//
// An item's result is registered after the store bytes it touches are handled,
// n_bytes being the store bytes the item touches (0 to 5); no new item is taken
// until the item before it is in the output register. The store's write port
// does one byte read-modify-write per cycle, overlapped with the next read.
// Clear, set position, zero-width and unused codes touch no store bytes; clear drops
// all per-byte valid bits at once, so no clearing pass follows reset.
// A stalled result holds in the output register; the next item is taken
// meanwhile and waits at its last step until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "lsb_first_bit_packer_core_assert.svh"

module lsb_first_bit_packer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [31:0] value,
    input  logic [5:0]  bit_count,
    input  logic [11:0] new_position,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_value,
    output logic [1:0]  status,
    output logic [11:0] position_after,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data
);

    import lsbp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_stat;

    lsbp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .dp_stat (dp_stat),
        .cmd     (cmd)
    );

    lsbp_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .dp_stat       (dp_stat),
        .func          (func),
        .value         (value),
        .bit_count     (bit_count),
        .new_position  (new_position),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_value    (read_value),
        .status        (status),
        .position_after(position_after),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    `LBP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `LBP_ASSERT_NEXT(a_finish_shows_result, clk, rst_n, cmd.finish, out_valid)
    `LBP_ASSERT_SAME(a_proc_in_span, clk, rst_n, cmd.proc_en, cmd.proc_idx < dp_stat.n_bytes)

endmodule
